@@ rtl/core/gmd_pkg.sv @@
package gmd_pkg;

    localparam int MaxDim   = 64;
    localparam int CoordW   = 6;
    localparam int CellW    = 12;
    localparam int DepthW   = 13;
    localparam int CfgW     = 7;
    localparam int CfgIdxW  = 1;

    localparam logic [CfgIdxW-1:0] CFG_WIDTH  = 1'b0;
    localparam logic [CfgIdxW-1:0] CFG_HEIGHT = 1'b1;

    typedef logic [MaxDim-1:0] row_t;

    function automatic logic [31:0] xorshift(input logic [31:0] s);
        logic [31:0] x;
        x = s ^ (s << 13);
        x = x ^ (x >> 17);
        x = x ^ (x << 5);
        return x;
    endfunction

endpackage

@@ rtl/core/gmd_if.sv @@
interface gmd_seed_if;
    logic        valid;
    logic        ready;
    logic [31:0] seed;
    modport source (output valid, output seed, input ready);
    modport sink   (input valid, input seed, output ready);
endinterface

interface gmd_row_if;
    logic        valid;
    logic        ready;
    logic [5:0]  row_index;
    logic [63:0] wall_bits;
    logic        last_row;
    modport source (output valid, output row_index, output wall_bits, output last_row,
                    input ready);
    modport sink   (input valid, input row_index, input wall_bits, input last_row,
                    output ready);
endinterface

@@ rtl/core/gmd_stack_ram.sv @@
module gmd_stack_ram
    import gmd_pkg::*;
(
    input  logic              clk,
    input  logic              we,
    input  logic [CellW-1:0]  waddr,
    input  logic [CellW-1:0]  wdata,
    input  logic [CellW-1:0]  raddr,
    output logic [CellW-1:0]  rdata
);

    logic [CellW-1:0] mem [0:(1<<CellW)-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/core/grid_maze_dfs_generator_core.sv @@
// Sequence: a clearing pass over the h rows of the row map, then each DFS step runs S_TOP,
//   the reads S_RD0..S_RD4 and S_DEC. Each carved cell is pushed once and popped once. Rows
//   follow, each read from the row map and then offered; a row is held while the sink is not ready.
// Throughput: one seed at a time; the next seed is taken once the last row transfers.
//   Five row reads per step through one read port set the step length.
// Reset: control idle, random state one, grid 64 x 64. The row map is rewritten
//   per start by a height-long clearing pass.
module grid_maze_dfs_generator_core
    import gmd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CfgIdxW-1:0]   cfg_index,
    input  logic [CfgW-1:0]      cfg_data,
    gmd_seed_if.sink             seed_in,
    gmd_row_if.source            row_out
);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_CLEAR = 10'b0000000010,
        S_TOP   = 10'b0000000100,
        S_RD0   = 10'b0000001000,
        S_RD1   = 10'b0000010000,
        S_RD2   = 10'b0000100000,
        S_RD3   = 10'b0001000000,
        S_RD4   = 10'b0010000000,
        S_DEC   = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    logic [CfgW-1:0]   gw_reg, gh_reg;
    logic [31:0]       rnd_reg;
    logic [DepthW-1:0] depth_reg;
    logic [CoordW-1:0] cx_reg, cy_reg;
    logic [CoordW:0]   w_reg, h_reg;
    logic [CoordW-1:0] row_cnt_reg;
    row_t              win_reg [0:3];   // rows cy-2..cy+1
    logic [2:0]        rcnt_reg;

    // row memory
    row_t              vmem [0:MaxDim-1];
    logic              vwe;
    logic [CoordW-1:0] vwaddr, vraddr;
    row_t              vwdata, vrdata;

    always_ff @(posedge clk)
    begin
        if (vwe)
        begin
            vmem[vwaddr] <= vwdata;
        end
        vrdata <= vmem[vraddr];
    end

    logic              swe;
    logic [CellW-1:0]  swaddr, swdata, sraddr, srdata;

    gmd_stack_ram u_stack (
        .clk   (clk),
        .we    (swe),
        .waddr (swaddr),
        .wdata (swdata),
        .raddr (sraddr),
        .rdata (srdata)
    );

    logic cfg_ok;
    assign cfg_ok = (gw_reg >= 7'd3) && (gh_reg >= 7'd3);

    // window access: row offset r in -2..2, column c
    function automatic logic vis(input row_t win [0:4], input int r, input int c,
                                 input logic [CoordW:0] h, input logic [CoordW:0] w,
                                 input logic [CoordW-1:0] cx, input logic [CoordW-1:0] cy);
        int yy, xx;
        yy = int'(cy) + r;
        xx = int'(cx) + c;
        if (yy < 0 || xx < 0 || yy >= int'(h) || xx >= int'(w))
            return 1'b0;
        return win[r+2][xx];
    endfunction

    // 4 = 16 = 256 = 65536 = 1 (mod 3), so fold digit sums down
    function automatic logic [1:0] mod3(input logic [31:0] v);
        logic [16:0] s1;
        logic [9:0]  s2;
        logic [6:0]  s3;
        logic [5:0]  s4;
        logic [4:0]  s5;
        s1 = {1'b0, v[31:16]} + {1'b0, v[15:0]};
        s2 = {1'b0, s1[16:8]} + {2'b0, s1[7:0]};
        s3 = {1'b0, s2[9:4]} + {3'b0, s2[3:0]};
        s4 = {1'b0, s3[6:2]} + {4'b0, s3[1:0]};
        s5 = {1'b0, s4[5:2]} + {3'b0, s4[1:0]};
        if (s5 >= 5'd6)
            return 2'(s5 - 5'd6);
        else if (s5 >= 5'd3)
            return 2'(s5 - 5'd3);
        return s5[1:0];
    endfunction

    // bottom row comes straight from the memory; current cell marked in place
    row_t win_cur [0:4];
    always_comb
    begin
        win_cur[0] = win_reg[0];
        win_cur[1] = win_reg[1];
        win_cur[2] = win_reg[2] | (row_t'(1) << cx_reg);
        win_cur[3] = win_reg[3];
        win_cur[4] = vrdata;
    end

    logic [3:0] cand;
    always_comb
    begin
        int dx, dy, nx, ny;
        logic ok;
        cand = '0;
        for (int d = 0; d < 4; d++)
        begin
            dx = (d == 1) ? -1 : (d == 2) ? 1 : 0;
            dy = (d == 0) ? -1 : (d == 3) ? 1 : 0;
            nx = int'(cx_reg) + dx;
            ny = int'(cy_reg) + dy;
            ok = !(nx <= 0 || ny <= 0 || nx >= int'(w_reg) - 1 || ny >= int'(h_reg) - 1);
            if (ok && vis(win_cur, dy, dx, h_reg, w_reg, cx_reg, cy_reg))
                ok = 1'b0;
            for (int a = 0; a <= 1; a++)
            begin
                for (int b = -1; b <= 1; b++)
                begin
                    if (!(a == 0 && b == 0))
                    begin
                        if (ok && vis(win_cur, dy + a*dy + b*dx, dx + a*dx + b*dy,
                                      h_reg, w_reg, cx_reg, cy_reg))
                            ok = 1'b0;
                    end
                end
            end
            cand[d] = ok;
        end
    end

    logic [31:0] rnd_nxt;
    logic [1:0]  rnd_m3_reg;
    logic [2:0]  ccount;
    logic [1:0]  sel, pick;
    assign rnd_nxt = xorshift(rnd_reg);
    assign ccount  = 3'($countones(cand));
    always_comb
    begin
        logic [1:0] k;
        case (ccount)
            3'd1: sel = 2'd0;
            3'd2: sel = {1'b0, rnd_nxt[0]};
            3'd3: sel = rnd_m3_reg;
            default: sel = rnd_nxt[1:0];
        endcase
        k = '0;
        pick = '0;
        for (int d = 0; d < 4; d++)
        begin
            if (cand[d])
            begin
                if (k == sel)
                    pick = 2'(d);
                k = k + 2'd1;
            end
        end
    end

    logic [CoordW-1:0] ncx, ncy;
    always_comb
    begin
        ncx = cx_reg;
        ncy = cy_reg;
        case (pick)
            2'd0: ncy = cy_reg - 6'd1;
            2'd1: ncx = cx_reg - 6'd1;
            2'd2: ncx = cx_reg + 6'd1;
            default: ncy = cy_reg + 6'd1;
        endcase
    end

    logic [1:0] rprev;
    assign rprev = 2'(rcnt_reg - 3'd1);

    // top-of-stack row comes from the stack read data during the first read, from cy_reg after it
    logic [CoordW-1:0] base_cy;
    assign base_cy = (state_reg == S_RD0) ? srdata[CellW-1:CoordW] : cy_reg;

    row_t wmask;
    assign wmask = (w_reg[CoordW]) ? '1 : ((row_t'(1) << w_reg[CoordW-1:0]) - row_t'(1));

    always_comb
    begin
        state_next = state_reg;
        vwe = 1'b0;
        vwaddr = '0;
        vwdata = '0;
        vraddr = row_cnt_reg;
        swe = 1'b0;
        swaddr = '0;
        swdata = '0;
        sraddr = 12'(depth_reg - 13'd1);
        case (state_reg)
            S_IDLE:
            begin
                if (seed_in.valid && cfg_ok)
                    state_next = S_CLEAR;
                swaddr = '0;
            end
            S_CLEAR:
            begin
                vwe = 1'b1;
                vwaddr = row_cnt_reg;
                if ({1'b0, row_cnt_reg} == h_reg - 7'd1)
                    state_next = S_TOP;
            end
            S_TOP: state_next = S_RD0;
            S_RD0, S_RD1, S_RD2, S_RD3, S_RD4:
            begin
                vraddr = base_cy + 6'(rcnt_reg) - 6'd2;
                if (state_reg == S_RD0)
                    state_next = S_RD1;
                else if (state_reg == S_RD1)
                    state_next = S_RD2;
                else if (state_reg == S_RD2)
                    state_next = S_RD3;
                else if (state_reg == S_RD3)
                    state_next = S_RD4;
                else
                    state_next = S_DEC;
            end
            S_DEC:
            begin
                if (ccount == 3'd0)
                begin
                    state_next = (depth_reg == 13'd1) ? S_OUT : S_TOP;
                end
                else
                begin
                    swe = (depth_reg < 13'd4096);
                    swaddr = 12'(depth_reg);
                    swdata = {ncy, ncx};
                    state_next = S_TOP;
                end
            end
            S_OUT:
            begin
                vraddr = row_cnt_reg;
                if (row_out.valid && row_out.ready && row_out.last_row)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
        if (state_reg == S_DEC)
        begin
            vwe = 1'b1;
            vwaddr = cy_reg;
            vwdata = win_cur[2];
        end
        if (state_reg == S_IDLE && seed_in.valid && cfg_ok)
        begin
            swe = 1'b1;
            swdata = {6'(gh_reg > 7'd64 ? 7'd32 : (gh_reg >> 1)),
                      6'(gw_reg > 7'd64 ? 7'd32 : (gw_reg >> 1))};
        end
    end

    // a seed on a too small grid is taken and dropped
    assign seed_in.ready = (state_reg == S_IDLE);

    logic out_v_reg;
    logic rd_pending_reg;
    assign row_out.valid     = out_v_reg;
    assign row_out.row_index = row_cnt_reg;
    assign row_out.wall_bits = ~vrdata & wmask;
    assign row_out.last_row  = ({1'b0, row_cnt_reg} == h_reg - 7'd1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            gw_reg      <= 7'd64;
            gh_reg      <= 7'd64;
            rnd_reg     <= 32'd1;
            depth_reg   <= '0;
            row_cnt_reg <= '0;
            rcnt_reg    <= '0;
            out_v_reg   <= 1'b0;
            rd_pending_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we && state_reg == S_IDLE)
            begin
                if (cfg_index == CFG_WIDTH)
                    gw_reg <= cfg_data;
                else
                    gh_reg <= cfg_data;
            end
            case (state_reg)
                S_IDLE:
                begin
                    row_cnt_reg <= '0;
                    if (seed_in.valid && cfg_ok)
                    begin
                        rnd_reg   <= (seed_in.seed == 32'd0) ? 32'd1 : seed_in.seed;
                        depth_reg <= 13'd1;
                    end
                end
                S_CLEAR:
                begin
                    row_cnt_reg <= (state_next == S_TOP) ? '0 : row_cnt_reg + 6'd1;
                end
                S_TOP:
                begin
                    rcnt_reg <= '0;
                end
                S_RD0, S_RD1, S_RD2, S_RD3, S_RD4:
                begin
                    rcnt_reg <= rcnt_reg + 3'd1;
                end
                S_DEC:
                begin
                    rcnt_reg <= '0;
                    if (ccount == 3'd0 || depth_reg >= 13'd4096)
                    begin
                        depth_reg <= depth_reg - 13'd1;
                    end
                    else
                    begin
                        depth_reg <= depth_reg + 13'd1;
                    end
                    if (ccount != 3'd0)
                    begin
                        rnd_reg <= rnd_nxt;
                    end
                    if (state_next == S_OUT)
                    begin
                        row_cnt_reg    <= '0;
                        rd_pending_reg <= 1'b1;
                    end
                end
                S_OUT:
                begin
                    if (rd_pending_reg)
                    begin
                        rd_pending_reg <= 1'b0;
                        out_v_reg      <= 1'b1;
                    end
                    else if (row_out.valid && row_out.ready)
                    begin
                        out_v_reg <= 1'b0;
                        if (!row_out.last_row)
                        begin
                            row_cnt_reg    <= row_cnt_reg + 6'd1;
                            rd_pending_reg <= 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // mod 3 of the next random word, sizes latched, top-of-stack cell and row window loads
    always_ff @(posedge clk)
    begin
        rnd_m3_reg <= mod3(rnd_nxt);
        if (state_reg == S_IDLE)
        begin
            w_reg <= (gw_reg > 7'd64) ? 7'd64 : gw_reg;
            h_reg <= (gh_reg > 7'd64) ? 7'd64 : gh_reg;
        end
        if (state_reg == S_RD0)
        begin
            cy_reg <= srdata[CellW-1:CoordW];
            cx_reg <= srdata[CoordW-1:0];
        end
        if (state_reg == S_RD1 || state_reg == S_RD2 || state_reg == S_RD3 ||
            state_reg == S_RD4)
        begin
            win_reg[rprev] <= vrdata;
        end
    end

    a_row_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (row_out.valid && !row_out.ready) |=> (row_out.valid &&
            $stable(row_out.row_index) && $stable(row_out.wall_bits) &&
            $stable(row_out.last_row)));

    a_row_in_out: assert property (@(posedge clk) disable iff (!rst_n)
        row_out.valid |-> (state_reg == S_OUT));

    a_depth_range: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= 13'd4096);

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
    import gmd_pkg::*;

    typedef struct packed {
        logic [5:0]  row_index;
        logic [63:0] wall_bits;
        logic        last_row;
    } maze_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic              cfg_we = 1'b0;
    logic [CfgIdxW-1:0] cfg_index = CFG_WIDTH;
    logic [CfgW-1:0]   cfg_data = '0;

    logic        seed_valid = 1'b0;
    logic [31:0] seed_word = '0;
    logic        row_ready = 1'b0;

    gmd_seed_if seed_ch ();
    gmd_row_if  row_ch ();

    assign seed_ch.valid = seed_valid;
    assign seed_ch.seed  = seed_word;
    assign row_ch.ready  = row_ready;

    grid_maze_dfs_generator_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .seed_in   (seed_ch.sink),
        .row_out   (row_ch.source)
    );

    // grid size as last written
    logic [CfgW-1:0] grid_cols = 7'd64;
    logic [CfgW-1:0] grid_rows = 7'd64;

    logic [31:0] pending_seeds[$];
    maze_row_t   expected_rows[$];
    int          error_count = 0;
    int          mazes_built = 0;
    int          seeds_sent = 0;
    int          rows_checked = 0;

    // carve scratch
    logic [63:0] visited[MaxDim];
    logic [11:0] path[MaxDim * MaxDim];

    function automatic bit cell_taken(int x, int y, int w, int h);
        if (x < 0 || y < 0 || x >= w || y >= h)
            return 1'b0;
        return visited[y][x];
    endfunction

    function automatic bit can_enter(int nx, int ny, int dx, int dy, int w, int h);
        int a;
        int b;
        if (nx <= 0 || ny <= 0 || nx >= w - 1 || ny >= h - 1)
            return 1'b0;
        if (cell_taken(nx, ny, w, h))
            return 1'b0;
        for (a = 0; a <= 1; a++)
            for (b = -1; b <= 1; b++)
                if (!(a == 0 && b == 0) &&
                    cell_taken(nx + a * dx + b * dy, ny + a * dy + b * dx, w, h))
                    return 1'b0;
        return 1'b1;
    endfunction

    function automatic void carve_maze(logic [31:0] seed_val);
        int          step_x[4];
        int          step_y[4];
        int          w;
        int          h;
        int          depth;
        int          cx;
        int          cy;
        int          cnt;
        int          pick;
        int          d;
        int          y;
        int          cand[4];
        logic [31:0] rnd;
        logic [63:0] mask;
        maze_row_t   r;
        step_x = '{0, -1, 1, 0};
        step_y = '{-1, 0, 0, 1};
        if (grid_cols < 3 || grid_rows < 3)
            return;
        w = (grid_cols > MaxDim) ? MaxDim : grid_cols;
        h = (grid_rows > MaxDim) ? MaxDim : grid_rows;
        rnd = (seed_val == 0) ? 32'd1 : seed_val;
        for (y = 0; y < MaxDim; y++)
            visited[y] = '0;
        path[0] = 12'((h / 2) * MaxDim + (w / 2));
        depth = 1;
        while (depth > 0) begin
            cx = path[depth - 1] % MaxDim;
            cy = path[depth - 1] / MaxDim;
            visited[cy][cx] = 1'b1;
            cnt = 0;
            for (d = 0; d < 4; d++)
                if (can_enter(cx + step_x[d], cy + step_y[d], step_x[d], step_y[d], w, h))
                begin
                    cand[cnt] = d;
                    cnt++;
                end
            if (cnt == 0) begin
                depth--;
            end
            else begin
                rnd = rnd ^ (rnd << 13);
                rnd = rnd ^ (rnd >> 17);
                rnd = rnd ^ (rnd << 5);
                pick = cand[rnd % cnt];
                if (depth < MaxDim * MaxDim) begin
                    path[depth] = 12'((cy + step_y[pick]) * MaxDim + cx + step_x[pick]);
                    depth++;
                end
                else begin
                    depth--;
                end
            end
        end
        mask = (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
        for (y = 0; y < h; y++) begin
            r.row_index = 6'(y);
            r.wall_bits = ~visited[y] & mask;
            r.last_row  = (y == h - 1);
            expected_rows.insert(expected_rows.size(), r);
        end
        mazes_built++;
    endfunction

    initial begin
        forever #5 clk = ~clk;
    end

    // seed driver: bursts of transfers separated by random gaps
    int burst_left = 3;
    int gap_left = 0;
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            seed_valid <= 1'b0;
        end
        else begin
            if (seed_valid && seed_ch.ready) begin
                carve_maze(seed_word);
                void'(pending_seeds.pop_front());
                seeds_sent++;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 5);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
                end
            end
            if (!(seed_valid && !seed_ch.ready)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    seed_valid <= 1'b0;
                end
                else if (pending_seeds.size() > 0) begin
                    seed_valid <= 1'b1;
                    seed_word <= pending_seeds[0];
                end
                else begin
                    seed_valid <= 1'b0;
                end
            end
        end
    end

    // row monitor with its own stall pattern
    int stall_mode = 0;
    int mode_left = 0;
    always @(posedge clk or negedge rst_n) begin
        maze_row_t want;
        if (!rst_n) begin
            row_ready <= 1'b0;
        end
        else begin
            if (row_ch.valid && row_ready) begin
                if (expected_rows.size() == 0) begin
                    $display("%0t: unexpected row transfer: row %0d walls %h last %0b", $time,
                             row_ch.row_index, row_ch.wall_bits, row_ch.last_row);
                    error_count++;
                end
                else begin
                    want = expected_rows.pop_front();
                    rows_checked++;
                    if (row_ch.row_index !== want.row_index) begin
                        $display("%0t: row_index expected %0d actual %0d", $time,
                                 want.row_index, row_ch.row_index);
                        error_count++;
                    end
                    if (row_ch.wall_bits !== want.wall_bits) begin
                        $display("%0t: row %0d wall_bits expected %h actual %h", $time,
                                 want.row_index, want.wall_bits, row_ch.wall_bits);
                        error_count++;
                    end
                    if (row_ch.last_row !== want.last_row) begin
                        $display("%0t: row %0d last_row expected %0b actual %0b", $time,
                                 want.row_index, want.last_row, row_ch.last_row);
                        error_count++;
                    end
                end
            end
            if (mode_left <= 0) begin
                stall_mode = $urandom_range(0, 2);
                mode_left = $urandom_range(10, 200);
            end
            mode_left--;
            case (stall_mode)
                0: row_ready <= 1'b1;
                1: row_ready <= ($urandom_range(0, 3) != 0);
                default: row_ready <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_WIDTH)
            grid_cols = val;
        else
            grid_rows = val;
    endtask

    task automatic drain;
        while (pending_seeds.size() > 0 || seed_valid || expected_rows.size() > 0)
            @(posedge clk);
        // items with too small a grid give no rows; let the block settle
        repeat (150) @(posedge clk);
    endtask

    task automatic run_phase(logic [CfgW-1:0] cols, logic [CfgW-1:0] rows, int n);
        int k;
        write_reg(CFG_WIDTH, cols);
        write_reg(CFG_HEIGHT, rows);
        for (k = 0; k < n; k++)
            pending_seeds.insert(pending_seeds.size(), $urandom());
        drain();
    endtask

    function automatic logic [CfgW-1:0] pick_size(bit allow_big);
        int sel;
        sel = $urandom_range(0, 19);
        if (sel == 0)
            return 7'($urandom_range(0, 2));
        if (sel == 1 && allow_big)
            return 7'($urandom_range(65, 127));
        if (sel < 5)
            return 7'($urandom_range(13, 40));
        return 7'($urandom_range(3, 12));
    endfunction

    initial begin
        int big_phases;
        int n;
        logic [CfgW-1:0] c;
        logic [CfgW-1:0] r;
        big_phases = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        // default 64 x 64 grid, zero seed, all-ones seed and seed one
        pending_seeds.insert(pending_seeds.size(), 32'd0);
        pending_seeds.insert(pending_seeds.size(), 32'hFFFF_FFFF);
        pending_seeds.insert(pending_seeds.size(), 32'd1);
        drain();
        write_reg(CFG_WIDTH, 7'd3);
        write_reg(CFG_HEIGHT, 7'd3);
        pending_seeds.insert(pending_seeds.size(), 32'd0);
        pending_seeds.insert(pending_seeds.size(), 32'h8000_0000);
        drain();
        run_phase(7'd3, 7'd64, 2);
        run_phase(7'd64, 7'd3, 2);
        run_phase(7'd127, 7'd100, 1);
        run_phase(7'd0, 7'd5, 2);
        run_phase(7'd2, 7'd2, 2);
        run_phase(7'd9, 7'd127, 1);
        run_phase(7'd5, 7'd7, 4);
        run_phase(7'd4, 7'd3, 3);

        while (seeds_sent < 100) begin
            c = pick_size(big_phases < 2);
            r = pick_size(big_phases < 2);
            if (c > 40 || r > 40) begin
                big_phases++;
                n = 1;
            end
            else begin
                n = $urandom_range(1, 10);
            end
            run_phase(c, r, n);
        end

        $display("%0d seeds sent, %0d mazes carved, %0d rows compared, %0d errors",
                 seeds_sent, mazes_built, rows_checked, error_count);
        $display("grid sizes covered 0..127 per axis, including saturation and empty grids");
        if (error_count == 0)
            $display("grid_maze_dfs_generator_core regression: pass");
        else
            $display("grid_maze_dfs_generator_core regression: fail");
        $finish;
    end

    initial begin
        #500_000_000;
        $display("%0t: timeout with %0d rows outstanding", $time, expected_rows.size());
        $display("grid_maze_dfs_generator_core regression: fail");
        $finish;
    end

endmodule
